// ----- rtl/core/nhfe_pkg.sv -----
// Shared types and constants for the host frame encoder.
// Holds the per-item command record that travels from the front end to the back end.
// No dependencies.
package nhfe_pkg;

    localparam logic [7:0] SPI_DW_BYTE  = 8'h01;
    localparam logic [7:0] PREAMBLE     = 8'h00;
    localparam logic [7:0] START_CODE0  = 8'h00;
    localparam logic [7:0] START_CODE1  = 8'hFF;
    localparam logic [7:0] TFI_HOST     = 8'hD4;
    localparam logic [7:0] POSTAMBLE    = 8'h00;
    localparam logic [7:0] LEN_MIN      = 8'd1;
    localparam logic [7:0] LEN_MAX      = 8'd254;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one classified payload byte
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       prefix;
        logic [7:0] lenf;
        logic       last;
        logic [7:0] dcs;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

// ----- rtl/core/nhfe_front.sv -----
// Front end: accepts payload bytes, tracks frame position and checksum, builds commands.
// Also holds the SPI prefix enable register. Depends on nhfe_pkg.
module nhfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_frame_length,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    input  nhfe_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output nhfe_pkg::t_cmd    o_cmd
);
    import nhfe_pkg::*;

    logic       r_in_frame;
    logic [7:0] r_bytes_left;
    logic [7:0] r_running_sum;
    logic       r_prefix_en;

    logic       n_in_frame;
    logic [7:0] n_bytes_left;
    logic [7:0] n_running_sum;

    logic [7:0] len_sat;
    logic [7:0] sum_base;
    logic [7:0] sum_new;
    logic [7:0] left_base;
    logic [7:0] left_new;
    logic       last;

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        if (i_frame_length == 8'd0) begin
            len_sat = LEN_MIN;
        end else if (i_frame_length == 8'hFF) begin
            len_sat = LEN_MAX;
        end else begin
            len_sat = i_frame_length;
        end
        sum_base  = r_in_frame ? r_running_sum : TFI_HOST;
        sum_new   = sum_base + i_data_byte;
        left_base = r_in_frame ? r_bytes_left : len_sat;
        left_new  = (left_base != 8'd0) ? left_base - 8'd1 : left_base;
        last      = (left_new == 8'd0);

        n_in_frame    = !last;
        n_bytes_left  = left_new;
        n_running_sum = last ? 8'd0 : sum_new;

        o_cmd.data   = i_data_byte;
        o_cmd.first  = !r_in_frame;
        o_cmd.prefix = r_prefix_en;
        o_cmd.lenf   = len_sat + 8'd1;
        o_cmd.last   = last;
        o_cmd.dcs    = 8'd0 - sum_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
            r_prefix_en   <= 1'b1;
        end else begin
            if (o_push) begin
                r_in_frame    <= n_in_frame;
                r_bytes_left  <= n_bytes_left;
                r_running_sum <= n_running_sum;
            end
            if (i_cfg_valid) begin
                r_prefix_en <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/core/nhfe_queue.sv -----
// Short command queue between front and back end.
// Register-based ring with one read port at the head. Depends on nhfe_pkg.
module nhfe_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nhfe_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output nhfe_pkg::t_cmd     o_head,
    output nhfe_pkg::t_q_stat  o_stat
);
    import nhfe_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == (QAW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.not_empty)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (!$past(i_rst_n) || r_count ==
             $past(r_count) + (QAW+1)'($past(i_push)) - (QAW+1)'($past(i_pop))))
        else $error("queue occupancy mismatch");

endmodule

// ----- rtl/core/nhfe_back.sv -----
// Back end: expands each queued command into frame bytes, one byte per cycle
// if not stalled; drives the registered output channel. Depends on nhfe_pkg.
module nhfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nhfe_pkg::t_cmd    i_head,
    input  nhfe_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_end
);
    import nhfe_pkg::*;

    typedef enum logic [3:0] {
        PH_PREFIX, PH_PRE, PH_START0, PH_START1, PH_LEN,
        PH_LCS, PH_TFI, PH_DATA, PH_DCS, PH_POST
    } t_phase;

    t_phase     r_phase;
    logic       r_mid;      // partway through the head command
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_end;

    t_phase     cur_phase;
    t_phase     n_phase;
    logic       done;
    logic       load;
    logic       emit;
    logic [7:0] byte_sel;

    assign load = !r_o_valid || !i_stall;
    assign emit = i_q_stat.not_empty && load;
    assign o_pop = emit && done;

    always_comb begin
        if (r_mid) begin
            cur_phase = r_phase;
        end else if (!i_head.first) begin
            cur_phase = PH_DATA;
        end else if (i_head.prefix) begin
            cur_phase = PH_PREFIX;
        end else begin
            cur_phase = PH_PRE;
        end

        done      = 1'b0;
        n_phase   = cur_phase;
        byte_sel  = 8'd0;
        unique case (cur_phase)
            PH_PREFIX: begin byte_sel = SPI_DW_BYTE;          n_phase = PH_PRE;      end
            PH_PRE:    begin byte_sel = PREAMBLE;             n_phase = PH_START0;   end
            PH_START0: begin byte_sel = START_CODE0;          n_phase = PH_START1;   end
            PH_START1: begin byte_sel = START_CODE1;          n_phase = PH_LEN;      end
            PH_LEN:    begin byte_sel = i_head.lenf;          n_phase = PH_LCS;      end
            PH_LCS:    begin byte_sel = 8'd0 - i_head.lenf;   n_phase = PH_TFI;      end
            PH_TFI:    begin byte_sel = TFI_HOST;             n_phase = PH_DATA;     end
            PH_DATA: begin
                byte_sel  = i_head.data;
                n_phase   = PH_DCS;
                done      = !i_head.last;
            end
            PH_DCS:    begin byte_sel = i_head.dcs;           n_phase = PH_POST;     end
            PH_POST:   begin byte_sel = POSTAMBLE;            done = 1'b1;           end
            default:   begin byte_sel = 8'd0;                 done = 1'b1;           end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PRE;
            r_mid     <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_byte  <= 8'd0;
            r_o_end   <= 1'b0;
        end else begin
            if (emit) begin
                r_mid   <= !done;
                r_phase <= n_phase;
            end
            if (load) begin
                r_o_valid <= emit;
                r_o_byte  <= byte_sel;
                r_o_end   <= emit && (cur_phase == PH_POST);
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_frame_end = r_o_end;

endmodule

// ----- rtl/core/nfc_host_frame_encoder.sv -----
// Host information frame encoder: payload bytes in, framed bytes out.
// An accepted byte passes the queue register, then the output register (empty queue).
// Throughput: one output byte per cycle when not stalled; middle payload bytes sustain
// one per cycle; a frame's first byte adds the header, its last the DCS and postamble.
// Reset (synchronous, active low) empties the queue and sets the SPI prefix enable.
// Depends on nhfe_pkg, nhfe_front, nhfe_queue, nhfe_back.
module nfc_host_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_frame_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import nhfe_pkg::*;

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    nhfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_length (i_frame_length),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    nhfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    nhfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule
